// ===== design/lpht_pkg.sv =====
package lpht_pkg;

    localparam int MaxEntries = 1024;
    localparam int HashW      = 32;
    localparam int ValueW     = 32;
    localparam int IdxW       = 10;
    localparam int StatusW    = 2;
    localparam int PctW       = 7;
    localparam logic [PctW-1:0] FillLimitReset = 7'd70;
    localparam int Percent    = 100;

    typedef enum logic [1:0] {
        ST_MISSING  = 2'd0,
        ST_FOUND    = 2'd1,
        ST_INSERTED = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HINT,
        S_PROBE,
        S_DECIDE,
        S_INSERT,
        S_CLR,
        S_RH_RD,
        S_RH_PL,
        S_CP_RD,
        S_CP_WR,
        S_RESTART,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              cmd;
        logic [HashW-1:0]  key_hash;
        logic [IdxW-1:0]   hint_index;
        logic [ValueW-1:0] new_value;
    } t_req;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [ValueW-1:0]  entry_value;
        logic [IdxW-1:0]    slot_index;
    } t_rsp;

    // memory port bundle from control to bank
    typedef struct packed {
        logic              we;
        logic [IdxW-1:0]   waddr;
        logic [HashW-1:0]  whash;
        logic [ValueW-1:0] wval;
        logic [IdxW-1:0]   raddr;
    } t_mem_ctl;

endpackage

// ===== design/lpht_bank.sv =====
module lpht_bank #(
    parameter int DEPTH  = lpht_pkg::MaxEntries,
    parameter int HASH_W = lpht_pkg::HashW,
    parameter int VAL_W  = lpht_pkg::ValueW,
    parameter int AW     = lpht_pkg::IdxW
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [HASH_W-1:0] i_whash,
    input  logic [VAL_W-1:0]  i_wval,
    input  logic [AW-1:0]     i_raddr,
    output logic [HASH_W-1:0] o_rhash,
    output logic [VAL_W-1:0]  o_rval
);

    logic [HASH_W-1:0] r_hash_mem [DEPTH];
    logic [VAL_W-1:0]  r_val_mem  [DEPTH];
    logic [HASH_W-1:0] r_rhash;
    logic [VAL_W-1:0]  r_rval;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_hash_mem[i_waddr] <= i_whash;
            r_val_mem[i_waddr]  <= i_wval;
        end
        r_rhash <= r_hash_mem[i_raddr];
        r_rval  <= r_val_mem[i_raddr];
    end

    assign o_rhash = r_rhash;
    assign o_rval  = r_rval;

endmodule

// ===== design/lpht_ctrl.sv =====
module lpht_ctrl #(
    parameter int MAX_ENTRIES = lpht_pkg::MaxEntries,
    parameter int HASH_W      = lpht_pkg::HashW,
    parameter int VAL_W       = lpht_pkg::ValueW,
    parameter int AW          = lpht_pkg::IdxW
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_stall,
    input  lpht_pkg::t_req            i_req,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_stall,
    output lpht_pkg::t_rsp            o_rsp,
    input  logic [lpht_pkg::PctW-1:0] i_fill_limit,
    output lpht_pkg::t_mem_ctl        o_main,
    input  logic [HASH_W-1:0]         i_main_hash,
    input  logic [VAL_W-1:0]          i_main_val,
    output lpht_pkg::t_mem_ctl        o_spare,
    input  logic [HASH_W-1:0]         i_spare_hash,
    input  logic [VAL_W-1:0]          i_spare_val
);

    localparam int CW = AW + 1;
    localparam int PW = CW + 7;

    lpht_pkg::t_state r_state, n_state;
    lpht_pkg::t_req   r_req, n_req;
    lpht_pkg::t_rsp   r_rsp, n_rsp;
    lpht_pkg::t_rsp   r_out, n_out;
    logic             r_rsp_valid, n_rsp_valid;
    logic [CW-1:0]    r_cap, n_cap;
    logic [CW-1:0]    r_count, n_count;
    logic [HASH_W-1:0] r_bloom, n_bloom;
    logic [AW-1:0]    r_k, n_k;
    logic [AW-1:0]    r_start, n_start;
    logic             r_free_ok, n_free_ok;
    logic [AW-1:0]    r_free, n_free;
    logic [CW-1:0]    r_i, n_i;
    logic [HASH_W-1:0] r_mv_hash, n_mv_hash;
    logic [VAL_W-1:0] r_mv_val, n_mv_val;
    logic [PW-1:0]    r_num, n_num;
    logic [PW-1:0]    r_den, n_den;

    logic [AW-1:0] mask, nmask;
    logic [CW-1:0] newcap;
    logic          can_grow;
    logic [AW-1:0] k_inc, k_inc_n;
    logic [HASH_W-1:0] h_in;

    assign mask    = AW'(r_cap - CW'(1));
    assign newcap  = (r_cap == '0) ? CW'(1) : CW'({r_cap, 1'b0});
    assign nmask   = AW'(newcap - CW'(1));
    assign can_grow = (r_cap == '0) || ({1'b0, r_cap, 1'b0} <= (CW+2)'(MAX_ENTRIES));
    assign k_inc   = (r_k + AW'(1)) & mask;
    assign k_inc_n = (r_k + AW'(1)) & nmask;
    assign h_in    = r_req.key_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpht_pkg::S_IDLE;
            r_rsp_valid <= 1'b0;
            r_cap       <= '0;
            r_count     <= '0;
            r_bloom     <= '0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_cap       <= n_cap;
            r_count     <= n_count;
            r_bloom     <= n_bloom;
        end
        r_req     <= n_req;
        r_rsp     <= n_rsp;
        r_out     <= n_out;
        r_k       <= n_k;
        r_start   <= n_start;
        r_free_ok <= n_free_ok;
        r_free    <= n_free;
        r_i       <= n_i;
        r_mv_hash <= n_mv_hash;
        r_mv_val  <= n_mv_val;
        r_num     <= n_num;
        r_den     <= n_den;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_rsp       = r_rsp;
        n_out       = r_out;
        n_rsp_valid = r_rsp_valid;
        n_cap       = r_cap;
        n_count     = r_count;
        n_bloom     = r_bloom;
        n_k         = r_k;
        n_start     = r_start;
        n_free_ok   = r_free_ok;
        n_free      = r_free;
        n_i         = r_i;
        n_mv_hash   = r_mv_hash;
        n_mv_val    = r_mv_val;
        n_num       = r_num;
        n_den       = r_den;
        o_main      = '0;
        o_spare     = '0;
        o_main.raddr  = r_k;
        o_spare.raddr = r_k;
        o_req_stall = (r_state != lpht_pkg::S_IDLE);

        if (r_rsp_valid && !i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            lpht_pkg::S_IDLE: begin
                if (i_req_valid && !o_req_stall) begin
                    n_req = i_req;
                    n_k   = i_req.hint_index & mask;
                    o_main.raddr = i_req.hint_index & mask;
                    n_rsp = '0;
                    if (i_req.key_hash == '0) begin
                        n_state = lpht_pkg::S_DONE;
                    end else if (!i_req.cmd && (((r_bloom & i_req.key_hash)
                                 != i_req.key_hash) || r_cap == '0)) begin
                        n_state = lpht_pkg::S_DONE;
                    end else if (r_cap == '0) begin
                        n_state = lpht_pkg::S_DECIDE;
                    end else begin
                        n_state = lpht_pkg::S_HINT;
                    end
                end
            end
            lpht_pkg::S_HINT: begin
                if (i_main_hash == h_in) begin
                    n_rsp.status      = lpht_pkg::ST_FOUND;
                    n_rsp.entry_value = i_main_val;
                    n_rsp.slot_index  = r_k;
                    n_state = lpht_pkg::S_DONE;
                end else begin
                    n_k     = AW'(h_in) & mask;
                    n_start = AW'(h_in) & mask;
                    o_main.raddr = AW'(h_in) & mask;
                    n_free_ok = 1'b0;
                    n_state = lpht_pkg::S_PROBE;
                end
            end
            lpht_pkg::S_PROBE: begin
                if (i_main_hash == h_in) begin
                    n_rsp.status      = lpht_pkg::ST_FOUND;
                    n_rsp.entry_value = i_main_val;
                    n_rsp.slot_index  = r_k;
                    n_state = lpht_pkg::S_DONE;
                end else if (i_main_hash == '0 || k_inc == r_start) begin
                    if (i_main_hash == '0) begin
                        n_free_ok = 1'b1;
                        n_free    = r_k;
                    end
                    if (!r_req.cmd) begin
                        n_state = lpht_pkg::S_DONE;
                    end else begin
                        n_num = PW'(r_count) * PW'(lpht_pkg::Percent);
                        n_den = '0;
                        n_state = lpht_pkg::S_DECIDE;
                    end
                end else begin
                    n_k = k_inc;
                    o_main.raddr = k_inc;
                end
            end
            lpht_pkg::S_DECIDE: begin
                // fill >= limit  <=>  count*100 >= limit*cap (truncation safe)
                if (r_cap != '0 && r_free_ok &&
                    ((r_num < PW'(i_fill_limit) * PW'(r_cap)) || !can_grow)) begin
                    n_state = lpht_pkg::S_INSERT;
                end else if (!can_grow) begin
                    n_rsp.status = lpht_pkg::ST_FULL;
                    n_state = lpht_pkg::S_DONE;
                end else begin
                    n_i = '0;
                    n_state = lpht_pkg::S_CLR;
                end
            end
            lpht_pkg::S_INSERT: begin
                o_main.we    = 1'b1;
                o_main.waddr = r_free;
                o_main.whash = h_in;
                o_main.wval  = r_req.new_value;
                n_count = r_count + CW'(1);
                n_bloom = r_bloom | h_in;
                n_rsp.status      = lpht_pkg::ST_INSERTED;
                n_rsp.entry_value = r_req.new_value;
                n_rsp.slot_index  = r_free;
                n_state = lpht_pkg::S_DONE;
            end
            lpht_pkg::S_CLR: begin
                o_spare.we    = 1'b1;
                o_spare.waddr = AW'(r_i);
                if (r_i == newcap - CW'(1)) begin
                    n_i = '0;
                    o_main.raddr = '0;
                    n_state = (r_cap == '0) ? lpht_pkg::S_CP_RD : lpht_pkg::S_RH_RD;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            lpht_pkg::S_RH_RD: begin
                // main read of entry r_i issued last cycle
                o_main.raddr = AW'(r_i);
                if (i_main_hash == '0) begin
                    if (r_i == r_cap - CW'(1)) begin
                        n_i = '0;
                        n_state = lpht_pkg::S_CP_RD;
                    end else begin
                        n_i = r_i + CW'(1);
                        o_main.raddr = AW'(r_i + CW'(1));
                    end
                end else begin
                    n_mv_hash = i_main_hash;
                    n_mv_val  = i_main_val;
                    n_k       = AW'(i_main_hash) & nmask;
                    o_spare.raddr = AW'(i_main_hash) & nmask;
                    n_state = lpht_pkg::S_RH_PL;
                end
            end
            lpht_pkg::S_RH_PL: begin
                if (i_spare_hash != '0) begin
                    n_k = k_inc_n;
                    o_spare.raddr = k_inc_n;
                end else begin
                    o_spare.we    = 1'b1;
                    o_spare.waddr = r_k;
                    o_spare.whash = r_mv_hash;
                    o_spare.wval  = r_mv_val;
                    if (r_i == r_cap - CW'(1)) begin
                        n_i = '0;
                        n_state = lpht_pkg::S_CP_RD;
                    end else begin
                        n_i = r_i + CW'(1);
                        o_main.raddr = AW'(r_i + CW'(1));
                        n_state = lpht_pkg::S_RH_RD;
                    end
                end
            end
            lpht_pkg::S_CP_RD: begin
                o_spare.raddr = AW'(r_i);
                n_state = lpht_pkg::S_CP_WR;
            end
            lpht_pkg::S_CP_WR: begin
                o_main.we    = 1'b1;
                o_main.waddr = AW'(r_i);
                o_main.whash = i_spare_hash;
                o_main.wval  = i_spare_val;
                if (r_i == newcap - CW'(1)) begin
                    n_cap = newcap;
                    // rerun the lookup on the grown table once the last copy has landed
                    n_k = r_req.hint_index & nmask;
                    n_state = lpht_pkg::S_RESTART;
                    n_i = '0;
                end else begin
                    n_i = r_i + CW'(1);
                    n_state = lpht_pkg::S_CP_RD;
                end
            end
            lpht_pkg::S_RESTART: begin
                // hint read goes out on r_k
                n_state = lpht_pkg::S_HINT;
            end
            lpht_pkg::S_DONE: begin
                if (!r_rsp_valid || !i_rsp_stall) begin
                    n_rsp_valid = 1'b1;
                    n_out = r_rsp;
                    n_state = lpht_pkg::S_IDLE;
                end
            end
            default: n_state = lpht_pkg::S_IDLE;
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_out;

endmodule

// ===== design/linear_probe_hash_table_core.sv =====
// On a hint hit the request passes the hint and done states before o_valid rises; each
// probed slot adds a probe step and an insert adds the decide and write states.
// Throughput: one request at a time; the next request is accepted in the idle state
// entered when the result is loaded into the output register, a load that waits while
// a stalled result still holds that register. Growth runs clear, rehash and copy back.
// Reset (synchronous, active low) empties the table: capacity, count and bloom
// go to zero and the fill limit to 70; no clearing pass is needed.
module linear_probe_hash_table_core #(
    parameter int MAX_ENTRIES = lpht_pkg::MaxEntries
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lpht_pkg::PctW-1:0] i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  lpht_pkg::t_req            i_req,
    output logic                      o_valid,
    input  logic                      i_stall,
    output lpht_pkg::t_rsp            o_rsp
);

    localparam int AW = lpht_pkg::IdxW;

    logic [lpht_pkg::PctW-1:0] r_fill_limit;
    lpht_pkg::t_mem_ctl main_ctl, spare_ctl;
    logic [lpht_pkg::HashW-1:0]  main_hash, spare_hash;
    logic [lpht_pkg::ValueW-1:0] main_val, spare_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= lpht_pkg::FillLimitReset;
        end else if (i_cfg_we) begin
            r_fill_limit <= i_cfg_wdata;
        end
    end

    lpht_ctrl #(.MAX_ENTRIES(MAX_ENTRIES), .AW(AW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_valid), .o_req_stall(o_stall), .i_req(i_req),
        .o_rsp_valid(o_valid), .i_rsp_stall(i_stall), .o_rsp(o_rsp),
        .i_fill_limit(r_fill_limit),
        .o_main(main_ctl), .i_main_hash(main_hash), .i_main_val(main_val),
        .o_spare(spare_ctl), .i_spare_hash(spare_hash), .i_spare_val(spare_val)
    );

    lpht_bank #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_main (
        .i_clk(i_clk), .i_we(main_ctl.we), .i_waddr(main_ctl.waddr),
        .i_whash(main_ctl.whash), .i_wval(main_ctl.wval),
        .i_raddr(main_ctl.raddr), .o_rhash(main_hash), .o_rval(main_val)
    );

    lpht_bank #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_spare (
        .i_clk(i_clk), .i_we(spare_ctl.we), .i_waddr(spare_ctl.waddr),
        .i_whash(spare_ctl.whash), .i_wval(spare_ctl.wval),
        .i_raddr(spare_ctl.raddr), .o_rhash(spare_hash), .o_rval(spare_val)
    );

endmodule

// ===== tb/tb_linear_probe_hash_table_core.sv =====
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_core;

    localparam int WatchdogLimit = 200000;
    localparam int PctW       = lpht_pkg::PctW;
    localparam int HashW      = lpht_pkg::HashW;
    localparam int ValueW     = lpht_pkg::ValueW;
    localparam int IdxW       = lpht_pkg::IdxW;
    localparam int MaxEntries = lpht_pkg::MaxEntries;
    localparam int Percent    = lpht_pkg::Percent;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [PctW-1:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    lpht_pkg::t_req i_req = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    lpht_pkg::t_rsp o_rsp;

    linear_probe_hash_table_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_req(i_req),
        .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    always #10 i_clk = ~i_clk;

    // table mirror
    logic [HashW-1:0]  tbl_hash [MaxEntries];
    logic [ValueW-1:0] tbl_val  [MaxEntries];
    logic [HashW-1:0]  sp_hash  [MaxEntries];
    logic [ValueW-1:0] sp_val   [MaxEntries];
    int unsigned tbl_cap, tbl_count, fill_limit;
    logic [HashW-1:0] bloom;

    lpht_pkg::t_req pending_reqs[$];
    lpht_pkg::t_rsp expected_rsps[$];
    logic [HashW-1:0] known_keys[$];
    int errors = 0;
    int n_accepted = 0, n_results = 0, n_grown = 0, n_full = 0;
    int idle_cycles = 0;
    bit long_hold = 1'b0;
    bit req_taken = 1'b0;
    bit moved;

    function automatic bit find_key(input logic [HashW-1:0] h, output int pos,
                                    output int free_pos);
        int unsigned mask, k, start;
        mask = tbl_cap - 1;
        start = h & mask;
        k = start;
        free_pos = -1;
        pos = -1;
        do begin
            if (tbl_hash[k] == h) begin
                pos = k;
                return 1'b1;
            end
            if (tbl_hash[k] == '0) begin
                free_pos = k;
                return 1'b0;
            end
            k = (k + 1) & mask;
        end while (k != start);
        return 1'b0;
    endfunction

    task automatic double_table();
        int unsigned ncap, nmask, k, n;
        ncap = (tbl_cap == 0) ? 1 : tbl_cap * 2;
        nmask = ncap - 1;
        for (int i = 0; i < ncap; i++) sp_hash[i] = '0;
        for (int i = 0; i < tbl_cap; i++) begin
            if (tbl_hash[i] != '0) begin
                k = tbl_hash[i] & nmask;
                for (n = 0; n < ncap && sp_hash[k] != '0; n++) k = (k + 1) & nmask;
                sp_hash[k] = tbl_hash[i];
                sp_val[k] = tbl_val[i];
            end
        end
        for (int i = 0; i < ncap; i++) begin
            tbl_hash[i] = sp_hash[i];
            tbl_val[i] = sp_val[i];
        end
        tbl_cap = ncap;
        n_grown++;
    endtask

    task automatic predict_lookup(input lpht_pkg::t_req r, output lpht_pkg::t_rsp rsp);
        int pos, fpos, e;
        bit grow_ok;
        int unsigned fill;
        logic [HashW-1:0] h;
        h = r.key_hash;
        rsp = '{status: lpht_pkg::ST_MISSING, entry_value: '0, slot_index: '0};
        if (h == '0) return;
        if (!r.cmd) begin
            if ((bloom & h) != h || tbl_cap == 0) return;
            e = r.hint_index & (tbl_cap - 1);
            if (tbl_hash[e] == h) begin
                rsp = '{lpht_pkg::ST_FOUND, tbl_val[e], IdxW'(e)};
            end else if (find_key(h, pos, fpos)) begin
                rsp = '{lpht_pkg::ST_FOUND, tbl_val[pos], IdxW'(pos)};
            end
            return;
        end
        forever begin
            grow_ok = (tbl_cap == 0) || (tbl_cap * 2 <= MaxEntries);
            if (tbl_cap != 0) begin
                e = r.hint_index & (tbl_cap - 1);
                if (tbl_hash[e] == h) begin
                    rsp = '{lpht_pkg::ST_FOUND, tbl_val[e], IdxW'(e)};
                    return;
                end
                if (find_key(h, pos, fpos)) begin
                    rsp = '{lpht_pkg::ST_FOUND, tbl_val[pos], IdxW'(pos)};
                    return;
                end
                fill = (tbl_count * Percent) / tbl_cap;
                if (fpos >= 0 && (fill < fill_limit || !grow_ok)) begin
                    tbl_hash[fpos] = h;
                    tbl_val[fpos] = r.new_value;
                    tbl_count++;
                    bloom |= h;
                    known_keys.push_back(h);
                    rsp = '{lpht_pkg::ST_INSERTED, r.new_value, IdxW'(fpos)};
                    return;
                end
            end
            if (!grow_ok) begin
                rsp = '{lpht_pkg::ST_FULL, '0, '0};
                n_full++;
                return;
            end
            double_table();
        end
    endtask

    // request taken at this rising edge
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_valid && !o_stall;
    end

    // driver: bursts and gaps
    int gap_left = 0, burst_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_taken) void'(pending_reqs.pop_front());
            if (!i_valid || req_taken) begin
                if (pending_reqs.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_req <= pending_reqs[0];
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    int hold_cnt = 0;
    always @(negedge i_clk) begin
        if (long_hold && hold_cnt < 300) begin
            hold_cnt++;
            i_stall <= 1'b1;
        end else begin
            case ($urandom_range(0, 7))
                0, 1: i_stall <= 1'b1;
                default: i_stall <= 1'b0;
            endcase
        end
    end

    // monitor
    lpht_pkg::t_rsp exp_r;
    lpht_pkg::t_rsp got_r;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_valid && !o_stall) begin
                predict_lookup(i_req, exp_r);
                expected_rsps.push_back(exp_r);
                n_accepted++;
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                n_results++;
                got_r = o_rsp;
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response status=%0d", got_r.status);
                    errors++;
                end else begin
                    exp_r = expected_rsps.pop_front();
                    if (got_r.status != exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, got_r.status);
                        errors++;
                    end
                    if (got_r.entry_value != exp_r.entry_value) begin
                        $error("entry_value exp %h got %h", exp_r.entry_value,
                               got_r.entry_value);
                        errors++;
                    end
                    if (got_r.slot_index != exp_r.slot_index) begin
                        $error("slot_index exp %0d got %0d", exp_r.slot_index,
                               got_r.slot_index);
                        errors++;
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("watchdog: no request or response for %0d cycles", idle_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic lpht_pkg::t_req mk_req(input logic c, input logic [HashW-1:0] h,
                                              input logic [IdxW-1:0] hint,
                                              input logic [ValueW-1:0] v);
        lpht_pkg::t_req r;
        r.cmd = c;
        r.key_hash = h;
        r.hint_index = hint;
        r.new_value = v;
        return r;
    endfunction

    function automatic logic [HashW-1:0] rand_key(input int unsigned nbits);
        logic [HashW-1:0] h;
        h = HashW'({$urandom, $urandom} & ((64'd1 << nbits) - 1));
        if (h == '0) h = 1;
        return h;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_fill_limit(input int unsigned pct);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= PctW'(pct);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        fill_limit = pct;
    endtask

    // one phase of random traffic; small key spaces keep hits frequent
    task automatic random_phase(input int n, input int unsigned keybits);
        logic [HashW-1:0] h;
        logic [IdxW-1:0] hint;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: h = '0;
                1, 2, 3: h = (known_keys.size() != 0) ?
                    known_keys[$urandom_range(0, known_keys.size() - 1)] :
                    rand_key(keybits);
                4: h = {$urandom};
                default: h = rand_key(keybits);
            endcase
            hint = ($urandom_range(0, 1) == 0) ? IdxW'(h) : IdxW'($urandom);
            pending_reqs.push_back(mk_req($urandom_range(0, 2) != 0, h, hint, $urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < MaxEntries; i++) begin
            tbl_hash[i] = '0;
            tbl_val[i] = '0;
            sp_hash[i] = '0;
            sp_val[i] = '0;
        end
        tbl_cap = 0;
        tbl_count = 0;
        bloom = '0;
        fill_limit = lpht_pkg::FillLimitReset;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, zero key, extremes, hint hits and misses
        pending_reqs.push_back(mk_req(1'b0, 32'h1, '0, '0));
        pending_reqs.push_back(mk_req(1'b1, '0, '1, '1));
        pending_reqs.push_back(mk_req(1'b0, '0, '0, '0));
        pending_reqs.push_back(mk_req(1'b1, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk_req(1'b1, 32'h1, '0, 32'h0));
        pending_reqs.push_back(mk_req(1'b0, 32'h1, '0, '0));
        pending_reqs.push_back(mk_req(1'b0, 32'hFFFF_FFFF, '1, '0));
        pending_reqs.push_back(mk_req(1'b1, 32'h8000_0000, 10'h200, 32'hA5A5_5A5A));
        pending_reqs.push_back(mk_req(1'b1, 32'h2, '0, 32'h5A5A_A5A5));
        pending_reqs.push_back(mk_req(1'b1, 32'h2, '1, 32'h1234));
        pending_reqs.push_back(mk_req(1'b0, 32'h3, '0, '0));
        pending_reqs.push_back(mk_req(1'b0, 32'h4, '0, '0));
        pending_reqs.push_back(mk_req(1'b1, 32'h4, 10'h155, 32'h1));
        pending_reqs.push_back(mk_req(1'b0, 32'h8000_0000, 10'h2AA, '0));
        wait_drained();

        // long receiver hold while the sender keeps offering
        long_hold = 1'b1;
        random_phase(200, 6);
        wait_drained();

        // limit 1: grows early, so capacity climbs to the ceiling; small key space
        set_fill_limit(1);
        random_phase(300, 7);
        wait_drained();

        // limit 100 then 127 (above fill): full table path
        set_fill_limit(100);
        random_phase(300, 10);
        wait_drained();
        set_fill_limit(127);
        random_phase(300, 11);
        wait_drained();

        // limit 0: grow first whenever the table can still grow
        set_fill_limit(0);
        random_phase(200, 8);
        wait_drained();

        set_fill_limit(50);
        random_phase(600, 12);
        wait_drained();

        $display("Covered %0d requests, %0d responses, %0d growth steps, %0d full answers;",
                 n_accepted, n_results, n_grown, n_full);
        $display("final capacity %0d with %0d entries over fill limits 0 to 127.",
                 tbl_cap, tbl_count);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/lpht_pkg.sv
design/lpht_bank.sv
design/lpht_ctrl.sv
design/linear_probe_hash_table_core.sv
tb/tb_linear_probe_hash_table_core.sv
